### rtl/core/svarr_pkg.sv
// svarr_pkg: beat types, command and status codes and register constants
// for the snapshot versioned array. No dependencies.

package svarr_pkg;

   // Field widths fixed by the interface
   localparam int TAG_W   = 16;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 7;
   localparam int ADDR_W  = 3;

   // Command codes
   localparam logic [1:0] CMD_SET  = 2'd0;
   localparam logic [1:0] CMD_SNAP = 2'd1;
   localparam logic [1:0] CMD_GET  = 2'd2;
   localparam logic [1:0] CMD_NOP  = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   // Register map
   localparam logic [ADDR_W-1:0] REG_ARRAY_LENGTH   = 3'd0;
   localparam logic [LEN_W-1:0]  ARRAY_LENGTH_RESET = 7'd64;

   localparam logic [TAG_W-1:0] EPOCH_MAX = 16'hFFFF;

   // Request beat
   typedef struct packed {
      logic [1:0]                cmd;
      logic [5:0]                index;
      logic signed [VALUE_W-1:0] value;
      logic [TAG_W-1:0]          snap_id;
   } svarr_req_type;

   // Response beat
   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [TAG_W-1:0]          snap_taken;
      logic [1:0]                status;
   } svarr_rsp_type;

   // History store strobes
   typedef struct packed {
      logic rd_last;   // read newest slot position of a row
      logic rd_slot;   // read tag and value of a slot
      logic wr_last;   // write newest slot position of a row
      logic wr_tag;    // write tag of a slot
      logic wr_val;    // write value of a slot
   } svarr_mem_ctl_type;

endpackage

### rtl/core/svarr_hist_mem.sv
// svarr_hist_mem: history store of the snapshot versioned array: per-row
// newest slot position plus tag and value slots. Uses svarr_pkg.

module svarr_hist_mem #(
   parameter int MAX_INDICES   = 64,
   parameter int HISTORY_DEPTH = 16,
   localparam int IDX_W = (MAX_INDICES > 1) ? $clog2(MAX_INDICES) : 1,
   localparam int POS_W = $clog2(HISTORY_DEPTH)
) (
   input  logic                            clock,
   input  svarr_pkg::svarr_mem_ctl_type    ctl,
   input  logic [IDX_W-1:0]                row,
   input  logic [POS_W-1:0]                slot,
   input  logic [POS_W-1:0]                wr_last_data,
   input  logic [svarr_pkg::TAG_W-1:0]     wr_tag_data,
   input  logic signed [svarr_pkg::VALUE_W-1:0] wr_val_data,
   output logic [POS_W-1:0]                rd_last_data,
   output logic [svarr_pkg::TAG_W-1:0]     rd_tag_data,
   output logic signed [svarr_pkg::VALUE_W-1:0] rd_val_data
);
   import svarr_pkg::*;

   localparam int ROWS  = 2 ** IDX_W;
   localparam int SLOTS = 2 ** (IDX_W + POS_W);

   logic [POS_W-1:0]          last_mem [ROWS];
   logic [TAG_W-1:0]          tag_mem  [SLOTS];
   logic signed [VALUE_W-1:0] val_mem  [SLOTS];

   logic [POS_W-1:0]          rd_last_ff;
   logic [TAG_W-1:0]          rd_tag_ff;
   logic signed [VALUE_W-1:0] rd_val_ff;

   logic [IDX_W+POS_W-1:0] slot_addr;

   assign slot_addr = {row, slot};

   // Newest slot position per row
   always_ff @(posedge clock) begin
      if (ctl.wr_last) begin
         last_mem[row] <= wr_last_data;
      end
      if (ctl.rd_last) begin
         rd_last_ff <= last_mem[row];
      end
   end

   // Tag slots
   always_ff @(posedge clock) begin
      if (ctl.wr_tag) begin
         tag_mem[slot_addr] <= wr_tag_data;
      end
      if (ctl.rd_slot) begin
         rd_tag_ff <= tag_mem[slot_addr];
      end
   end

   // Value slots
   always_ff @(posedge clock) begin
      if (ctl.wr_val) begin
         val_mem[slot_addr] <= wr_val_data;
      end
      if (ctl.rd_slot) begin
         rd_val_ff <= val_mem[slot_addr];
      end
   end

   assign rd_last_data = rd_last_ff;
   assign rd_tag_data  = rd_tag_ff;
   assign rd_val_data  = rd_val_ff;

endmodule

### rtl/core/snapshot_versioned_array.sv
// Snapshot versioned array: one item at a time. Snap, no-op and out-of-range
// beats: S_DISP, S_DONE. Set: S_DISP, S_LAST, S_SETCHK, S_DONE. Get: S_DISP,
// S_LAST, an S_PROBE/S_CMP pair per binary search probe through the single tag
// read port (at most ceil(log2(row entries)), so at most ceil(log2(HISTORY_DEPTH))),
// then S_PROBE, S_VAL, S_DONE. Reset is synchronous; afterward a clearing pass
// resets every row to the pair (0,0), with req_stall high. Uses svarr_pkg.

module snapshot_versioned_array #(
   parameter int MAX_INDICES   = 64,
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  svarr_pkg::svarr_req_type           req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output svarr_pkg::svarr_rsp_type           rsp_data,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [svarr_pkg::ADDR_W-1:0]       paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import svarr_pkg::*;

   localparam int IDX_W = (MAX_INDICES > 1) ? $clog2(MAX_INDICES) : 1;
   localparam int POS_W = $clog2(HISTORY_DEPTH);
   localparam int WIDE_W = 13;

   localparam logic [IDX_W-1:0]  LAST_ROW  = IDX_W'(MAX_INDICES - 1);
   localparam logic [POS_W-1:0]  FULL_POS  = POS_W'(HISTORY_DEPTH - 1);
   localparam logic [WIDE_W-1:0] MAX_LEN   = WIDE_W'(MAX_INDICES);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DISP   = 3'd1;
   localparam logic [2:0] S_LAST   = 3'd2;
   localparam logic [2:0] S_SETCHK = 3'd3;
   localparam logic [2:0] S_PROBE  = 3'd4;
   localparam logic [2:0] S_CMP    = 3'd5;
   localparam logic [2:0] S_VAL    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]          state_ff, state_in;
   svarr_req_type       item_ff, item_in;
   logic                clr_ff, clr_in;
   logic [IDX_W-1:0]    clr_row_ff, clr_row_in;
   logic [TAG_W-1:0]    epoch_ff, epoch_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [POS_W-1:0]    last_ff, last_in;
   logic [POS_W-1:0]    lo_ff, lo_in;
   logic [POS_W-1:0]    hi_ff, hi_in;
   logic [POS_W-1:0]    mid_ff, mid_in;
   svarr_rsp_type       res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   svarr_rsp_type       rsp_data_ff, rsp_data_in;

   // history store port
   svarr_mem_ctl_type          mem_ctl;
   logic [IDX_W-1:0]           mem_row;
   logic [POS_W-1:0]           mem_slot;
   logic [POS_W-1:0]           wr_last_data;
   logic [TAG_W-1:0]           wr_tag_data;
   logic signed [VALUE_W-1:0]  wr_val_data;
   logic [POS_W-1:0]           rd_last_data;
   logic [TAG_W-1:0]           rd_tag_data;
   logic signed [VALUE_W-1:0]  rd_val_data;

   logic [WIDE_W-1:0]   idx_wide;
   logic [WIDE_W-1:0]   len_wide;
   logic [WIDE_W-1:0]   len_eff;
   logic                in_range;
   logic [IDX_W-1:0]    row;

   // shared compare and midpoint unit
   logic [TAG_W-1:0]    cmp_a, cmp_b;
   logic                cmp_gt;
   logic [POS_W:0]      span;
   logic [POS_W:0]      mid_wide;
   logic [POS_W-1:0]    mid_calc;

   logic                req_accept;
   logic                cfg_write;

   // Index check against the clamped length
   assign idx_wide = WIDE_W'(item_ff.index);
   assign len_wide = WIDE_W'(len_ff);
   assign len_eff  = (len_wide > MAX_LEN) ? MAX_LEN : len_wide;
   assign in_range = idx_wide < len_eff;
   assign row      = idx_wide[IDX_W-1:0];

   // Comparator: epoch against newest tag on set, probed tag against snap_id on get
   assign cmp_a  = (state_ff == S_SETCHK) ? epoch_ff : rd_tag_data;
   assign cmp_b  = (state_ff == S_SETCHK) ? rd_tag_data : item_ff.snap_id;
   assign cmp_gt = cmp_a > cmp_b;

   // Upper midpoint of the search window
   assign span     = {1'b0, hi_ff} - {1'b0, lo_ff} + (POS_W+1)'(1);
   assign mid_wide = {1'b0, lo_ff} + (span >> 1);
   assign mid_calc = mid_wide[POS_W-1:0];

   assign req_stall  = (state_ff != S_IDLE) || clr_ff;
   assign req_accept = req_valid && !req_stall;

   // Register port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr == REG_ARRAY_LENGTH);
   assign prdata    = (paddr == REG_ARRAY_LENGTH) ? 32'(len_ff) : 32'd0;
   assign len_in    = cfg_write ? pwdata[LEN_W-1:0] : len_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      clr_in       = clr_ff;
      clr_row_in   = clr_row_ff;
      epoch_in     = epoch_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_ctl      = '0;
      mem_row      = row;
      mem_slot     = '0;
      wr_last_data = '0;
      wr_tag_data  = '0;
      wr_val_data  = '0;

      // clearing pass: each row back to the single pair (0,0)
      if (clr_ff) begin
         mem_row        = clr_row_ff;
         mem_ctl.wr_last = 1'b1;
         mem_ctl.wr_tag  = 1'b1;
         mem_ctl.wr_val  = 1'b1;
         if (clr_row_ff == LAST_ROW) begin
            clr_in = 1'b0;
         end else begin
            clr_row_in = clr_row_ff + IDX_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               item_in  = req_data;
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            res_in = '0;
            case (item_ff.cmd)
               CMD_SET, CMD_GET: begin
                  if (in_range) begin
                     mem_ctl.rd_last = 1'b1;
                     state_in        = S_LAST;
                  end else begin
                     res_in.status = ST_RANGE;
                     state_in      = S_DONE;
                  end
               end
               CMD_SNAP: begin
                  if (epoch_ff == EPOCH_MAX) begin
                     res_in.status = ST_SAT;
                  end else begin
                     res_in.snap_taken = epoch_ff;
                     epoch_in          = epoch_ff + TAG_W'(1);
                  end
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_LAST: begin
            last_in = rd_last_data;
            if (item_ff.cmd == CMD_SET) begin
               mem_ctl.rd_slot = 1'b1;
               mem_slot        = rd_last_data;
               state_in        = S_SETCHK;
            end else begin
               lo_in    = '0;
               hi_in    = rd_last_data;
               state_in = S_PROBE;
            end
         end

         // set: append under a newer epoch (status FULL if the row is full), else overwrite the newest value
         S_SETCHK: begin
            res_in = '0;
            if (cmp_gt) begin
               if (last_ff == FULL_POS) begin
                  res_in.status = ST_FULL;
               end else begin
                  mem_slot        = last_ff + POS_W'(1);
                  mem_ctl.wr_last = 1'b1;
                  mem_ctl.wr_tag  = 1'b1;
                  mem_ctl.wr_val  = 1'b1;
                  wr_last_data    = last_ff + POS_W'(1);
                  wr_tag_data     = epoch_ff;
                  wr_val_data     = item_ff.value;
               end
            end else begin
               mem_slot       = last_ff;
               mem_ctl.wr_val = 1'b1;
               wr_val_data    = item_ff.value;
            end
            state_in = S_DONE;
         end

         // get: one probe per pass until the window closes
         S_PROBE: begin
            mem_ctl.rd_slot = 1'b1;
            if (lo_ff == hi_ff) begin
               mem_slot = hi_ff;
               state_in = S_VAL;
            end else begin
               mid_in   = mid_calc;
               mem_slot = mid_calc;
               state_in = S_CMP;
            end
         end

         S_CMP: begin
            if (cmp_gt) begin
               hi_in = mid_ff - POS_W'(1);
            end else begin
               lo_in = mid_ff;
            end
            state_in = S_PROBE;
         end

         S_VAL: begin
            res_in            = '0;
            res_in.read_value = rd_val_data;
            state_in          = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_ff       <= 1'b1;
         clr_row_ff   <= '0;
         epoch_ff     <= '0;
         len_ff       <= ARRAY_LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_row_ff   <= clr_row_in;
         epoch_ff     <= epoch_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      last_ff     <= last_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   svarr_hist_mem #(
      .MAX_INDICES   (MAX_INDICES),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist_mem (
      .clock        (clock),
      .ctl          (mem_ctl),
      .row          (mem_row),
      .slot         (mem_slot),
      .wr_last_data (wr_last_data),
      .wr_tag_data  (wr_tag_data),
      .wr_val_data  (wr_val_data),
      .rd_last_data (rd_last_data),
      .rd_tag_data  (rd_tag_data),
      .rd_val_data  (rd_val_data)
   );

endmodule

### rtl/core/svarr_chk.sv
// svarr_chk: port-level checks of the snapshot versioned array, bound to
// the top level. Uses svarr_pkg.

module svarr_chk (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input svarr_pkg::svarr_rsp_type rsp_data
);
   import svarr_pkg::*;

   // the clearing pass holds off requests right after reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   // one item in flight: the beat just taken blocks the next
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   // no result can appear the cycle after a request beat
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("response too early");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind snapshot_versioned_array svarr_chk u_svarr_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
